// ===== rtl/cbcv_pkg.sv =====
package cbcv_pkg;

  // Number of readings in one voting group.
  localparam int VOTE_COUNT = 5;
  localparam int IDX_W      = $clog2(VOTE_COUNT + 1);
  localparam int TALLY_W    = $clog2(VOTE_COUNT + 1);

  localparam int WIDTH_W    = 16;
  localparam int TOL_W      = 8;
  localparam int CENTER_W   = 6;
  localparam int NUM_BOXES  = 4;
  localparam int NUM_CLASSES = 5;

  typedef logic [2:0] colour_t;

  localparam colour_t CLASS_NONE   = 3'd0;
  localparam colour_t CLASS_RED    = 3'd1;
  localparam colour_t CLASS_GREEN  = 3'd2;
  localparam colour_t CLASS_YELLOW = 3'd3;
  localparam colour_t CLASS_BLUE   = 3'd4;

  typedef struct packed {
    logic [CENTER_W-1:0] r;
    logic [CENTER_W-1:0] g;
    logic [CENTER_W-1:0] b;
  } center_t;

  // Box centers, box 0 is tested first.
  localparam center_t [NUM_BOXES-1:0] BOX_CENTER = {
    center_t'{r: 6'd37, g: 6'd19, b: 6'd11},  // blue
    center_t'{r: 6'd8,  g: 6'd10, b: 6'd17},  // yellow
    center_t'{r: 6'd23, g: 6'd16, b: 6'd26},  // green
    center_t'{r: 6'd14, g: 6'd47, b: 6'd37}   // red
  };

  localparam colour_t [NUM_BOXES-1:0] BOX_CLASS = {
    CLASS_BLUE, CLASS_YELLOW, CLASS_GREEN, CLASS_RED
  };

  // Classified reading handed from the classify stage to the vote stage.
  typedef struct packed {
    logic    valid;
    colour_t cls;
    logic    last;
  } cls_item_t;

endpackage

// ===== rtl/cbcv_box_lane.sv =====
module cbcv_box_lane
  import cbcv_pkg::*;
(
  input  logic [WIDTH_W-1:0] red_width,
  input  logic [WIDTH_W-1:0] green_width,
  input  logic [WIDTH_W-1:0] blue_width,
  input  logic [TOL_W-1:0]   tolerance,
  input  center_t            center,
  output logic               hit
);

  localparam int SUM_W = WIDTH_W + 1;

  // center - tol < w < center + tol, rewritten as w + tol > center so that
  // a negative lower bound needs no signed arithmetic.
  function automatic logic in_band(input logic [WIDTH_W-1:0] w,
                                   input logic [CENTER_W-1:0] c,
                                   input logic [TOL_W-1:0] t);
    logic [SUM_W-1:0] w_ext;
    logic [SUM_W-1:0] c_ext;
    logic [SUM_W-1:0] t_ext;
    w_ext = SUM_W'(w);
    c_ext = SUM_W'(c);
    t_ext = SUM_W'(t);
    return ((w_ext + t_ext) > c_ext) && (w_ext < (c_ext + t_ext));
  endfunction

  assign hit = in_band(red_width, center.r, tolerance) &&
               in_band(green_width, center.g, tolerance) &&
               in_band(blue_width, center.b, tolerance);

endmodule

// ===== rtl/cbcv_vote.sv =====
module cbcv_vote
  import cbcv_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cls_item_t item,
  output logic      take,
  output logic      out_valid,
  input  logic      out_stall,
  output colour_t   out_voted_colour,
  output logic      out_colour_changed,
  output colour_t   out_previous_colour
);

  logic [TALLY_W-1:0] tally_r   [NUM_CLASSES];
  logic [TALLY_W-1:0] tally_nxt [NUM_CLASSES];
  logic [TALLY_W-1:0] tally_inc [NUM_CLASSES];
  colour_t current_r, current_nxt;
  colour_t last_r, last_nxt;
  logic    out_valid_r, out_valid_nxt;
  colour_t out_voted_r;
  logic    out_changed_r;
  colour_t out_prev_r;
  colour_t voted;
  logic    changed;
  logic    emit;

  // The closing reading of a group waits only while the output register
  // holds an untaken result.
  assign take = item.valid && !(item.last && out_valid_r && out_stall);
  assign emit = take && item.last;

  always_comb begin
    for (int k = 0; k < NUM_CLASSES; k++) begin
      tally_inc[k] = tally_r[k] + TALLY_W'(item.cls == colour_t'(k));
    end
    // Strictly greater wins, so ties keep the lower code.
    voted = CLASS_NONE;
    for (int k = 1; k < NUM_CLASSES; k++) begin
      if (tally_inc[k] > tally_inc[voted]) begin
        voted = colour_t'(k);
      end
    end
    changed     = (voted != current_r);
    current_nxt = current_r;
    last_nxt    = last_r;
    if (emit && changed) begin
      last_nxt    = current_r;
      current_nxt = voted;
    end
    for (int k = 0; k < NUM_CLASSES; k++) begin
      if (emit) begin
        tally_nxt[k] = '0;
      end else if (take) begin
        tally_nxt[k] = tally_inc[k];
      end else begin
        tally_nxt[k] = tally_r[k];
      end
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_CLASSES; k++) begin
        tally_r[k] <= '0;
      end
      current_r   <= CLASS_NONE;
      last_r      <= CLASS_NONE;
      out_valid_r <= 1'b0;
    end else begin
      tally_r     <= tally_nxt;
      current_r   <= current_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_voted_r   <= voted;
      out_changed_r <= changed;
      out_prev_r    <= last_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_voted_colour    = out_voted_r;
  assign out_colour_changed  = out_changed_r;
  assign out_previous_colour = out_prev_r;

  a_rise_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(emit))
    else $error("result appeared without a closing reading");

  a_changed_differs: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_changed_r |-> out_prev_r != out_voted_r)
    else $error("changed flag set but previous equals voted colour");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !emit)
    else $error("stalled result overwritten");

  a_tally_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> tally_r[0] == '0 && tally_r[4] == '0)
    else $error("tally not cleared after vote");

endmodule

// ===== rtl/colour_box_classifier_vote.sv =====
// Colour box classifier with majority vote.
//
// Input channel: in_red_width, in_green_width and in_blue_width form one
// reading, moved by a transfer when in_valid is high and in_stall is low.
// Each reading is checked against four colour boxes by four parallel lanes;
// the first box (red, green, yellow, blue) that holds all three widths gives
// the class, otherwise the class is none.
// Result channel: one result per group of VOTE_COUNT readings, carrying the
// majority colour, a changed flag and the stored previous colour. A result
// moves by a transfer when out_valid is high and out_stall is low.
// Configuration: cfg_wr_en with cfg_wr_data writes the box tolerance at that
// clock edge; write it only while the block is idle.
// Pipeline: the result of a group becomes valid after the transfer of its last
// reading (one classify register, one vote/output register); a stalled result can delay it.
// Throughput: one reading per cycle. in_stall rises only when the last
// reading of a group sits in the classify register while an untaken result
// is stalled in the output register; other readings keep flowing.
// Reset (synchronous, rst_n low) empties both registers, clears the tally,
// the group position and the stored colours, and sets the tolerance to 9.
module colour_box_classifier_vote
  import cbcv_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [TOL_W-1:0]   cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [WIDTH_W-1:0] in_red_width,
  input  logic [WIDTH_W-1:0] in_green_width,
  input  logic [WIDTH_W-1:0] in_blue_width,
  output logic               out_valid,
  input  logic               out_stall,
  output colour_t            out_voted_colour,
  output logic               out_colour_changed,
  output colour_t            out_previous_colour
);

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(9);
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(VOTE_COUNT - 1);

  logic [TOL_W-1:0] tol_r;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             s1_valid_r, s1_valid_nxt;
  colour_t          s1_cls_r;
  logic             s1_last_r;
  logic [NUM_BOXES-1:0] hit;
  colour_t          cls;
  logic             in_xfer;
  logic             take;
  cls_item_t        s1_item;

  // Tolerance register, written directly by the configuration port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_wr_en) begin
      tol_r <= cfg_wr_data;
    end
  end

  // One lane per colour box, all testing the same reading.
  for (genvar g = 0; g < NUM_BOXES; g++) begin : g_lane
    cbcv_box_lane u_lane (
      .red_width   (in_red_width),
      .green_width (in_green_width),
      .blue_width  (in_blue_width),
      .tolerance   (tol_r),
      .center      (BOX_CENTER[g]),
      .hit         (hit[g])
    );
  end

  // Merge: the lowest-numbered box that hits wins.
  always_comb begin
    cls = CLASS_NONE;
    for (int k = NUM_BOXES - 1; k >= 0; k--) begin
      if (hit[k]) begin
        cls = BOX_CLASS[k];
      end
    end
  end

  // The classify register is free when empty or when the vote stage takes
  // its reading this cycle.
  assign in_stall = s1_valid_r && !take;
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    idx_nxt = idx_r;
    if (in_xfer) begin
      idx_nxt = (idx_r == IDX_LAST) ? '0 : idx_r + IDX_W'(1);
    end
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (take) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      idx_r      <= idx_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_cls_r  <= cls;
      s1_last_r <= (idx_r == IDX_LAST);
    end
  end

  assign s1_item.valid = s1_valid_r;
  assign s1_item.cls   = s1_cls_r;
  assign s1_item.last  = s1_last_r;

  cbcv_vote u_vote (
    .clk                 (clk),
    .rst_n               (rst_n),
    .item                (s1_item),
    .take                (take),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_voted_colour    (out_voted_colour),
    .out_colour_changed  (out_colour_changed),
    .out_previous_colour (out_previous_colour)
  );

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= IDX_LAST)
    else $error("group position out of range");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && s1_last_r)
    else $error("input stalled without a waiting closing reading");

  a_group_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && idx_r == IDX_LAST |=> idx_r == '0 && s1_last_r)
    else $error("group did not close after its last reading");

endmodule

// ===== tb/tb_colour_box_classifier_vote.sv =====
module tb_colour_box_classifier_vote;
  import cbcv_pkg::*;

  // Run bounds. The limit is taken many times over the slowest correct run.
  localparam int RUN_LIMIT     = 200000;
  // Cycles allowed after the last result of a phase. Readings that end no
  // group can still sit in the classify register at that point.
  localparam int SETTLE_CYCLES = 6;
  // Length of the one long receiver hold-off, in cycles.
  localparam int LONG_HOLD     = 80;

  // One RGB reading as it is driven onto the input channel.
  typedef struct packed {
    logic [WIDTH_W-1:0] r;
    logic [WIDTH_W-1:0] g;
    logic [WIDTH_W-1:0] b;
  } reading_t;

  // One vote result as it should appear on the result channel.
  typedef struct packed {
    colour_t voted;
    logic    changed;
    colour_t prev;
  } vote_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_wr_en = 1'b0;
  logic [TOL_W-1:0]   cfg_wr_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [WIDTH_W-1:0] in_red_width = '0;
  logic [WIDTH_W-1:0] in_green_width = '0;
  logic [WIDTH_W-1:0] in_blue_width = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  colour_t            out_voted_colour;
  logic               out_colour_changed;
  colour_t            out_previous_colour;

  colour_box_classifier_vote u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_red_width        (in_red_width),
    .in_green_width      (in_green_width),
    .in_blue_width       (in_blue_width),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_voted_colour    (out_voted_colour),
    .out_colour_changed  (out_colour_changed),
    .out_previous_colour (out_previous_colour)
  );

  // Readings waiting to be offered, and vote results waiting to be seen.
  reading_t reading_fifo[$];
  vote_t    expected_votes[$];

  // Shadow copy of the block's state, advanced on every input transfer.
  logic [TOL_W-1:0] tol_shadow;
  logic [2:0]       class_tally [NUM_CLASSES];
  logic [2:0]       group_pos;
  colour_t          cur_colour;
  colour_t          stored_prev;

  // Knobs set by the stimulus sequence.
  bit src_idle_on  = 1'b1;
  bit sink_idle_on = 1'b1;
  bit hold_armed   = 1'b0;

  // Handshake bookkeeping shared between the edges.
  logic in_took = 1'b0;
  int   src_gap = 0;
  int   sink_gap = 0;
  int   hold_count = 0;

  // Run statistics.
  int unsigned cycle_count = 0;
  int fail_count = 0;
  int mismatch_count = 0;
  int readings_moved = 0;
  int votes_checked = 0;
  int input_stall_cycles = 0;
  int tol_settings = 0;

  // Free-running clock, period 20.
  initial begin
    forever #10 clk = ~clk;
  end

  // Box centers per channel (0 red, 1 green, 2 blue), box order red, green,
  // yellow, blue. This is the test's own copy of the color table.
  function automatic int box_centre(input int k, input int ch);
    int c;
    c = 0;
    case (k)
      0: c = (ch == 0) ? 14 : (ch == 1) ? 47 : 37;
      1: c = (ch == 0) ? 23 : (ch == 1) ? 16 : 26;
      2: c = (ch == 0) ? 8  : (ch == 1) ? 10 : 17;
      3: c = (ch == 0) ? 37 : (ch == 1) ? 19 : 11;
      default: c = 0;
    endcase
    return c;
  endfunction

  function automatic colour_t box_colour(input int k);
    colour_t cls;
    case (k)
      0: cls = CLASS_RED;
      1: cls = CLASS_GREEN;
      2: cls = CLASS_YELLOW;
      default: cls = CLASS_BLUE;
    endcase
    return cls;
  endfunction

  function automatic int channel_of(input reading_t rd, input int ch);
    int w;
    case (ch)
      0: w = rd.r;
      1: w = rd.g;
      default: w = rd.b;
    endcase
    return w;
  endfunction

  // First box that strictly holds all three widths. The bounds are signed,
  // so a tolerance larger than the center lets a width of zero pass below.
  function automatic colour_t classify_reading(input reading_t rd, input logic [TOL_W-1:0] tol);
    int  t;
    int  w;
    int  c;
    bit  fits;
    t = tol;
    for (int k = 0; k < NUM_BOXES; k++) begin
      fits = 1'b1;
      for (int ch = 0; ch < 3; ch++) begin
        w = channel_of(rd, ch);
        c = box_centre(k, ch);
        if (!((w > c - t) && (w < c + t)))
          fits = 1'b0;
      end
      if (fits)
        return box_colour(k);
    end
    return CLASS_NONE;
  endfunction

  function automatic void clear_tally();
    for (int k = 0; k < NUM_CLASSES; k++)
      class_tally[k] = '0;
    group_pos = '0;
  endfunction

  // Counts one reading into the shadow tally. On the last reading of a group
  // it returns 1 and the vote result; ties go to the lower color code.
  function automatic bit predict_vote(input reading_t rd, output vote_t res);
    colour_t cls;
    colour_t voted;
    cls = classify_reading(rd, tol_shadow);
    class_tally[cls] = class_tally[cls] + 3'd1;
    group_pos = group_pos + 3'd1;
    res = '0;
    if (group_pos < VOTE_COUNT)
      return 1'b0;
    voted = CLASS_NONE;
    for (int k = 1; k < NUM_CLASSES; k++) begin
      if (class_tally[k] > class_tally[voted])
        voted = colour_t'(k);
    end
    clear_tally();
    res.voted = voted;
    if (voted == cur_colour) begin
      res.changed = 1'b0;
    end else begin
      res.changed = 1'b1;
      stored_prev = cur_colour;
      cur_colour = voted;
    end
    res.prev = stored_prev;
    return 1'b1;
  endfunction

  // Sampling at the rising edge: the shadow state follows every register
  // write and every input transfer, and every result transfer is checked
  // against the oldest expected vote.
  always @(posedge clk) begin : monitor_proc
    vote_t res;
    vote_t want;
    if (!rst_n) begin
      tol_shadow = 8'd9;
      clear_tally();
      cur_colour = CLASS_NONE;
      stored_prev = CLASS_NONE;
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && !in_stall;
      if (cfg_wr_en)
        tol_shadow = cfg_wr_data;
      if (in_valid && in_stall)
        input_stall_cycles++;
      if (in_valid && !in_stall) begin
        readings_moved++;
        if (predict_vote({in_red_width, in_green_width, in_blue_width}, res))
          expected_votes.push_back(res);
      end
      if (out_valid && !out_stall) begin
        if (expected_votes.size() == 0) begin
          fail_count++;
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result transfer: voted %0d changed %0d previous %0d",
                     out_voted_colour, out_colour_changed, out_previous_colour);
        end else begin
          want = expected_votes.pop_front();
          votes_checked++;
          if (out_voted_colour !== want.voted || out_colour_changed !== want.changed ||
              out_previous_colour !== want.prev) begin
            fail_count++;
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("vote %0d mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                       votes_checked, want.voted, want.changed, want.prev,
                       out_voted_colour, out_colour_changed, out_previous_colour);
          end
        end
      end
    end
  end

  // Sender, driven at the falling edge. A reading that has been offered is
  // held unchanged until its transfer; only then may the next one follow,
  // possibly after a random idle burst.
  always @(negedge clk) begin : drive_proc
    reading_t rd;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_took)) begin
      if (src_gap > 0) begin
        in_valid <= 1'b0;
        src_gap--;
      end else if (src_idle_on && $urandom_range(0, 5) == 0) begin
        in_valid <= 1'b0;
        src_gap = $urandom_range(0, 3);
      end else if (reading_fifo.size() > 0) begin
        rd = reading_fifo.pop_front();
        in_valid <= 1'b1;
        in_red_width <= rd.r;
        in_green_width <= rd.g;
        in_blue_width <= rd.b;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver, driven at the falling edge. Once armed, it holds off for a
  // long stretch counted here; otherwise it stalls in random short bursts.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_armed && hold_count < LONG_HOLD) begin
      out_stall <= 1'b1;
      hold_count++;
    end else if (sink_gap > 0) begin
      out_stall <= 1'b1;
      sink_gap--;
    end else if (sink_idle_on && $urandom_range(0, 4) == 0) begin
      out_stall <= 1'b1;
      sink_gap = $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("colour_box_classifier_vote regression: fail");
      $finish;
    end
  end

  task automatic queue_rgb(input int r, input int g, input int b);
    reading_t rd;
    rd.r = r[WIDTH_W-1:0];
    rd.g = g[WIDTH_W-1:0];
    rd.b = b[WIDTH_W-1:0];
    reading_fifo.push_back(rd);
  endtask

  // A reading strictly inside box k, kept at or above zero. With a zero
  // tolerance no box can hold anything, so a random reading is used.
  function automatic reading_t reading_in_box(input int k, input int tol);
    reading_t rd;
    int w [3];
    int lo;
    int hi;
    int c;
    for (int ch = 0; ch < 3; ch++) begin
      c = box_centre(k, ch);
      if (tol == 0) begin
        w[ch] = $urandom_range(0, 65535);
      end else begin
        lo = (c - tol + 1 < 0) ? 0 : c - tol + 1;
        hi = c + tol - 1;
        w[ch] = $urandom_range(hi, lo);
      end
    end
    rd.r = w[0][WIDTH_W-1:0];
    rd.g = w[1][WIDTH_W-1:0];
    rd.b = w[2][WIDTH_W-1:0];
    return rd;
  endfunction

  // A reading meant to miss: fully random, one channel sitting exactly on a
  // box edge, or one channel far out of range.
  function automatic reading_t reading_outside(input int tol);
    reading_t rd;
    int k;
    int ch;
    int c;
    int w;
    k = $urandom_range(0, NUM_BOXES - 1);
    ch = $urandom_range(0, 2);
    case ($urandom_range(0, 2))
      0: begin
        rd.r = WIDTH_W'($urandom_range(0, 65535));
        rd.g = WIDTH_W'($urandom_range(0, 65535));
        rd.b = WIDTH_W'($urandom_range(0, 65535));
      end
      1: begin
        rd.r = WIDTH_W'(box_centre(k, 0));
        rd.g = WIDTH_W'(box_centre(k, 1));
        rd.b = WIDTH_W'(box_centre(k, 2));
        c = box_centre(k, ch);
        w = (c - tol >= 0 && $urandom_range(0, 1)) ? c - tol : c + tol;
        if (ch == 0) rd.r = w[WIDTH_W-1:0];
        else if (ch == 1) rd.g = w[WIDTH_W-1:0];
        else rd.b = w[WIDTH_W-1:0];
      end
      default: begin
        rd = reading_in_box(k, tol);
        w = $urandom_range(1000, 65535);
        if (ch == 0) rd.r = w[WIDTH_W-1:0];
        else if (ch == 1) rd.g = w[WIDTH_W-1:0];
        else rd.b = w[WIDTH_W-1:0];
      end
    endcase
    return rd;
  endfunction

  // Five readings, most of them of one target color so the vote is steered
  // while ties and mixed groups still turn up.
  task automatic queue_group(input int tol);
    int target;
    int cls;
    target = $urandom_range(0, NUM_CLASSES - 1);
    for (int n = 0; n < VOTE_COUNT; n++) begin
      cls = ($urandom_range(0, 9) < 7) ? target : $urandom_range(0, NUM_CLASSES - 1);
      if (cls == CLASS_NONE)
        reading_fifo.push_back(reading_outside(tol));
      else
        reading_fifo.push_back(reading_in_box(cls - 1, tol));
    end
  endtask

  task automatic write_tolerance(input int tol);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= tol[TOL_W-1:0];
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    tol_settings++;
  endtask

  // Waits until every reading has moved and every vote has come out, then
  // lets the pipeline empty of readings that ended no group.
  task automatic drain_and_settle();
    while (reading_fifo.size() != 0 || in_valid || expected_votes.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Whole groups with single stray readings mixed in. The strays shift the
  // group boundaries, so later groups straddle the intended ones.
  task automatic run_phase(input int tol, input int groups, input int strays);
    int left;
    write_tolerance(tol);
    left = strays;
    for (int n = 0; n < groups; n++) begin
      queue_group(tol);
      if (left > 0 && $urandom_range(0, 1)) begin
        reading_fifo.push_back(reading_outside(tol));
        left--;
      end
    end
    while (left > 0) begin
      reading_fifo.push_back(reading_outside(tol));
      left--;
    end
    drain_and_settle();
  endtask

  initial begin
    // Reset once, released at a falling edge.
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset tolerance, written explicitly as well.
    write_tolerance(9);
    // Every box center once plus a zero reading: a five-way tie votes none.
    queue_rgb(14, 47, 37);
    queue_rgb(23, 16, 26);
    queue_rgb(8, 10, 17);
    queue_rgb(37, 19, 11);
    queue_rgb(0, 0, 0);
    // Red at both inner edges and the center: red wins, color changes.
    queue_rgb(22, 55, 45);
    queue_rgb(6, 39, 29);
    queue_rgb(14, 47, 37);
    queue_rgb(14, 47, 37);
    queue_rgb(14, 47, 37);
    // Exact edges fail the strict bounds; none and green tie, none wins.
    queue_rgb(5, 47, 37);
    queue_rgb(23, 16, 26);
    queue_rgb(31, 24, 34);
    queue_rgb(29, 11, 3);
    queue_rgb(65535, 0, 65535);
    // None and yellow tie at two each, so none wins.
    queue_rgb(23, 47, 37);
    queue_rgb(65535, 65535, 65535);
    queue_rgb(8, 10, 17);
    queue_rgb(8, 10, 17);
    queue_rgb(37, 19, 11);
    drain_and_settle();

    // Largest tolerance: the lower bounds go negative, so zero fits red.
    write_tolerance(255);
    queue_rgb(0, 0, 0);
    queue_rgb(0, 65535, 0);
    queue_rgb(268, 301, 291);
    queue_rgb(269, 0, 0);
    queue_rgb(0, 0, 0);
    drain_and_settle();

    // Random part across several tolerance settings, extremes first.
    run_phase(0, 8, 5);
    run_phase(255, 10, 5);
    run_phase(1, 10, 5);
    run_phase($urandom_range(2, 40), 16, 10);
    run_phase($urandom_range(0, 255), 10, 5);
    run_phase(9, 10, 5);

    // Back-pressure: the sender keeps offering while the receiver holds off
    // long enough for both registers to fill and the input to stall.
    src_idle_on = 1'b0;
    hold_armed = 1'b1;
    run_phase(12, 12, 0);

    // Final stretch with no idling on either side.
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    run_phase($urandom_range(4, 30), 16, 10);

    if (expected_votes.size() != 0) begin
      fail_count += expected_votes.size();
      $display("%0d expected votes never arrived", expected_votes.size());
    end
    $display("Moved %0d readings and checked %0d votes under %0d tolerance writes.",
             readings_moved, votes_checked, tol_settings);
    $display("Input was held off for %0d cycles; %0d result mismatches.",
             input_stall_cycles, mismatch_count);
    if (fail_count == 0) begin
      $display("colour_box_classifier_vote regression: pass");
    end else begin
      $display("colour_box_classifier_vote regression: fail");
    end
    $finish;
  end

endmodule
